// ===== sv/qmn_pkg.sv =====
// shared widths for the normalized quaternion product datapath
package qmn_pkg;

    localparam int IW   = 32;       // input and result component width
    localparam int PW   = 64;       // one signed 32x32 partial product
    localparam int CW   = 66;       // exact signed product component
    localparam int MAGW = 65;       // magnitude of a product component
    localparam int HW   = 33;       // high slice of a magnitude
    localparam int LW   = 32;       // low slice of a magnitude
    localparam int SQW  = 130;      // square of a magnitude
    localparam int NW   = 132;      // sum of four squares
    localparam int LANES = 4;

endpackage

// ===== sv/qmn_hamilton.sv =====
// two-stage hamilton product: sixteen multipliers, then signed four-term sums
module qmn_hamilton
    import qmn_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [IW-1:0] now_q [LANES],
    input  logic signed [IW-1:0] old_q [LANES],
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [CW-1:0] c_out [LANES]
);

    logic                 v1_reg, v2_reg;
    logic                 rdy1, rdy2;
    logic signed [PW-1:0] p_reg [LANES][LANES];
    logic signed [CW-1:0] c_reg [LANES];
    logic signed [CW-1:0] c_next [LANES];
    logic signed [CW-1:0] e [LANES][LANES];

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            for (int j = 0; j < LANES; j++) begin
                e[i][j] = CW'(p_reg[i][j]);
            end
        end
        c_next[0] = e[0][0] - e[1][1] - e[2][2] - e[3][3];
        c_next[1] = e[0][1] + e[1][0] + e[2][3] - e[3][2];
        c_next[2] = e[0][2] - e[1][3] + e[2][0] + e[3][1];
        c_next[3] = e[0][3] + e[1][2] - e[2][1] + e[3][0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            for (int i = 0; i < LANES; i++) begin
                for (int j = 0; j < LANES; j++) begin
                    p_reg[i][j] <= now_q[i] * old_q[j];
                end
            end
        end
        if (rdy2) begin
            c_reg <= c_next;
        end
    end

    assign out_valid = v2_reg;
    assign c_out     = c_reg;

endmodule

// ===== sv/qmn_norm.sv =====
// five-stage magnitude, square and four-square sum
module qmn_norm
    import qmn_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [CW-1:0] c_in [LANES],
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SQW-1:0]       sq_out [LANES],
    output logic                 neg_out [LANES],
    output logic [NW-1:0]        nrm_out,
    output logic                 zero_out
);

    localparam int NS = 5;

    logic [NS-1:0]     v_reg;
    logic [NS-1:0]     rdy;

    // stage 1: sign and magnitude
    logic [MAGW-1:0]   mag_reg  [LANES];
    logic              neg1_reg [LANES];
    // stage 2: partial squares
    logic [2*HW-1:0]   hh_reg   [LANES];
    logic [HW+LW-1:0]  hl_reg   [LANES];
    logic [2*LW-1:0]   ll_reg   [LANES];
    logic              neg2_reg [LANES];
    logic              zero2_reg;
    // stage 3: full squares
    logic [SQW-1:0]    sq3_reg  [LANES];
    logic              neg3_reg [LANES];
    logic              zero3_reg;
    // stage 4: pair sums
    logic [NW-1:0]     n01_reg, n23_reg;
    logic [SQW-1:0]    sq4_reg  [LANES];
    logic              neg4_reg [LANES];
    logic              zero4_reg;
    // stage 5: norm
    logic [NW-1:0]     nrm_reg;
    logic [SQW-1:0]    sq5_reg  [LANES];
    logic              neg5_reg [LANES];
    logic              zero5_reg;

    logic [CW-1:0]     abs_c    [LANES];
    logic              all_zero;

    always_comb begin
        rdy[NS-1] = !v_reg[NS-1] || out_ready;
        for (int s = NS - 2; s >= 0; s--) begin
            rdy[s] = !v_reg[s] || rdy[s+1];
        end
    end
    assign in_ready = rdy[0];

    always_comb begin
        all_zero = 1'b1;
        for (int i = 0; i < LANES; i++) begin
            abs_c[i] = c_in[i][CW-1] ? (CW'(0) - c_in[i]) : c_in[i];
            if (mag_reg[i] != '0) all_zero = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) v_reg[0] <= in_valid;
            for (int s = 1; s < NS; s++) begin
                if (rdy[s]) v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            for (int i = 0; i < LANES; i++) begin
                mag_reg[i]  <= abs_c[i][MAGW-1:0];
                neg1_reg[i] <= c_in[i][CW-1];
            end
        end
        if (rdy[1]) begin
            for (int i = 0; i < LANES; i++) begin
                hh_reg[i]   <= mag_reg[i][MAGW-1:LW] * mag_reg[i][MAGW-1:LW];
                hl_reg[i]   <= mag_reg[i][MAGW-1:LW] * mag_reg[i][LW-1:0];
                ll_reg[i]   <= mag_reg[i][LW-1:0] * mag_reg[i][LW-1:0];
                neg2_reg[i] <= neg1_reg[i];
            end
            zero2_reg <= all_zero;
        end
        if (rdy[2]) begin
            for (int i = 0; i < LANES; i++) begin
                sq3_reg[i]  <= (SQW'(hh_reg[i]) << (2*LW)) + (SQW'(hl_reg[i]) << (LW+1))
                             + SQW'(ll_reg[i]);
                neg3_reg[i] <= neg2_reg[i];
            end
            zero3_reg <= zero2_reg;
        end
        if (rdy[3]) begin
            n01_reg   <= NW'(sq3_reg[0]) + NW'(sq3_reg[1]);
            n23_reg   <= NW'(sq3_reg[2]) + NW'(sq3_reg[3]);
            sq4_reg   <= sq3_reg;
            neg4_reg  <= neg3_reg;
            zero4_reg <= zero3_reg;
        end
        if (rdy[4]) begin
            nrm_reg   <= n01_reg + n23_reg;
            sq5_reg   <= sq4_reg;
            neg5_reg  <= neg4_reg;
            zero5_reg <= zero4_reg;
        end
    end

    assign out_valid = v_reg[NS-1];
    assign sq_out    = sq5_reg;
    assign neg_out   = neg5_reg;
    assign nrm_out   = nrm_reg;
    assign zero_out  = zero5_reg;

endmodule

// ===== sv/qmn_rsqrt_step.sv =====
// one registered bit of the exact c * 2^f / sqrt(n) digit recurrence, four lanes
module qmn_rsqrt_step
    import qmn_pkg::*;
#(
    parameter int FRAC_BITS = 30,
    parameter int BIT       = 0
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [NW+2*FRAC_BITS:0] r_in  [LANES],
    input  logic [NW+2*FRAC_BITS:0] p_in  [LANES],
    input  logic [FRAC_BITS:0]      k_in  [LANES],
    input  logic                    neg_in [LANES],
    input  logic [NW-1:0]           nrm_in,
    input  logic                    zero_in,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [NW+2*FRAC_BITS:0] r_out [LANES],
    output logic [NW+2*FRAC_BITS:0] p_out [LANES],
    output logic [FRAC_BITS:0]      k_out [LANES],
    output logic                    neg_out [LANES],
    output logic [NW-1:0]           nrm_out,
    output logic                    zero_out
);

    localparam int RW = NW + 2*FRAC_BITS + 1;
    localparam int KW = FRAC_BITS + 1;

    logic          v_reg;
    logic          rdy;
    logic [RW-1:0] t    [LANES];
    logic [RW:0]   diff [LANES];
    logic [RW-1:0] r_reg [LANES];
    logic [RW-1:0] p_reg [LANES];
    logic [KW-1:0] k_reg [LANES];
    logic          neg_reg [LANES];
    logic [NW-1:0] nrm_reg;
    logic          zero_reg;

    assign rdy      = !v_reg || out_ready;
    assign in_ready = rdy;

    // trial k + 2^b: (k + 2^b)^2 n - k^2 n = 2^(b+1) k n + 2^(2b) n
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            t[i]    = (p_in[i] << (BIT+1)) + (RW'(nrm_in) << (2*BIT));
            diff[i] = {1'b0, r_in[i]} - {1'b0, t[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (rdy) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy) begin
            for (int i = 0; i < LANES; i++) begin
                if (!diff[i][RW]) begin
                    r_reg[i] <= diff[i][RW-1:0];
                    p_reg[i] <= p_in[i] + (RW'(nrm_in) << BIT);
                    k_reg[i] <= k_in[i] | (KW'(1) << BIT);
                end else begin
                    r_reg[i] <= r_in[i];
                    p_reg[i] <= p_in[i];
                    k_reg[i] <= k_in[i];
                end
            end
            neg_reg  <= neg_in;
            nrm_reg  <= nrm_in;
            zero_reg <= zero_in;
        end
    end

    assign out_valid = v_reg;
    assign r_out     = r_reg;
    assign p_out     = p_reg;
    assign k_out     = k_reg;
    assign neg_out   = neg_reg;
    assign nrm_out   = nrm_reg;
    assign zero_out  = zero_reg;

endmodule

// ===== sv/quaternion_multiply_normalize.sv =====
// normalized hamilton product
// throughput one request per cycle unless m_ready stalls; one rsqrt bit per stage
// stages: 2 product, 5 norm, FRAC_BITS + 1 recurrence, 1 output register
// each stage stalls only when it holds data that cannot move on, so bubbles collapse
// reset (aresetn low, synchronous) clears every stage valid bit; data is not reset
module quaternion_multiply_normalize
    import qmn_pkg::*;
#(
    parameter int FRAC_BITS = 30
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [IW-1:0] s_now_w,
    input  logic signed [IW-1:0] s_now_x,
    input  logic signed [IW-1:0] s_now_y,
    input  logic signed [IW-1:0] s_now_z,
    input  logic signed [IW-1:0] s_old_w,
    input  logic signed [IW-1:0] s_old_x,
    input  logic signed [IW-1:0] s_old_y,
    input  logic signed [IW-1:0] s_old_z,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [IW-1:0] m_prod_w,
    output logic signed [IW-1:0] m_prod_x,
    output logic signed [IW-1:0] m_prod_y,
    output logic signed [IW-1:0] m_prod_z,
    output logic                 m_norm_zero
);

    localparam int RW    = NW + 2*FRAC_BITS + 1;   // recurrence remainder width
    localparam int KW    = FRAC_BITS + 1;          // result magnitude width
    localparam int STEPS = FRAC_BITS + 1;          // one result bit per stage

    // component vectors
    logic signed [IW-1:0] now_q [LANES];
    logic signed [IW-1:0] old_q [LANES];

    // hamilton -> norm
    logic                 ham_valid, norm_ready;
    logic signed [CW-1:0] c_ham [LANES];

    // norm -> recurrence
    logic                 norm_valid;
    logic [SQW-1:0]       sq_n  [LANES];
    logic                 neg_n [LANES];
    logic [NW-1:0]        nrm_n;
    logic                 zero_n;

    // recurrence chain, index 0 is the chain input
    logic                 st_valid [STEPS+1];
    logic                 st_ready [STEPS+1];
    logic [RW-1:0]        r_s   [STEPS+1][LANES];
    logic [RW-1:0]        p_s   [STEPS+1][LANES];
    logic [KW-1:0]        k_s   [STEPS+1][LANES];
    logic                 neg_s [STEPS+1][LANES];
    logic [NW-1:0]        nrm_s [STEPS+1];
    logic                 zero_s [STEPS+1];

    // output register
    logic                 out_valid_reg;
    logic                 out_ready;
    logic signed [IW-1:0] prod_reg  [LANES];
    logic signed [IW-1:0] prod_next [LANES];
    logic                 zero_reg;

    assign now_q[0] = s_now_w;
    assign now_q[1] = s_now_x;
    assign now_q[2] = s_now_y;
    assign now_q[3] = s_now_z;
    assign old_q[0] = s_old_w;
    assign old_q[1] = s_old_x;
    assign old_q[2] = s_old_y;
    assign old_q[3] = s_old_z;

    // exact 66-bit product components
    qmn_hamilton u_ham (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .now_q     (now_q),
        .old_q     (old_q),
        .out_valid (ham_valid),
        .out_ready (norm_ready),
        .c_out     (c_ham)
    );

    // squares and their sum, sign kept for the end
    qmn_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ham_valid),
        .in_ready  (norm_ready),
        .c_in      (c_ham),
        .out_valid (norm_valid),
        .out_ready (st_ready[0]),
        .sq_out    (sq_n),
        .neg_out   (neg_n),
        .nrm_out   (nrm_n),
        .zero_out  (zero_n)
    );

    // chain input: remainder starts at c^2 * 2^(2f), k and k*n at zero
    always_comb begin
        st_valid[0] = norm_valid;
        for (int i = 0; i < LANES; i++) begin
            r_s[0][i]   = RW'(sq_n[i]) << (2*FRAC_BITS);
            p_s[0][i]   = '0;
            k_s[0][i]   = '0;
            neg_s[0][i] = neg_n[i];
        end
        nrm_s[0]  = nrm_n;
        zero_s[0] = zero_n;
    end

    // largest k with k^2 * n <= c^2 * 2^(2f), decided from the top bit down
    for (genvar j = 0; j < STEPS; j++) begin : g_step
        qmn_rsqrt_step #(
            .FRAC_BITS (FRAC_BITS),
            .BIT       (FRAC_BITS - j)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (st_valid[j]),
            .in_ready  (st_ready[j]),
            .r_in      (r_s[j]),
            .p_in      (p_s[j]),
            .k_in      (k_s[j]),
            .neg_in    (neg_s[j]),
            .nrm_in    (nrm_s[j]),
            .zero_in   (zero_s[j]),
            .out_valid (st_valid[j+1]),
            .out_ready (st_ready[j+1]),
            .r_out     (r_s[j+1]),
            .p_out     (p_s[j+1]),
            .k_out     (k_s[j+1]),
            .neg_out   (neg_s[j+1]),
            .nrm_out   (nrm_s[j+1]),
            .zero_out  (zero_s[j+1])
        );
    end

    // output register takes a request whenever it is empty or being drained
    assign out_ready        = !out_valid_reg || m_ready;
    assign st_ready[STEPS]  = out_ready;

    // sign restore; zero norm forces a zero result
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            if (zero_s[STEPS]) begin
                prod_next[i] = '0;
            end else if (neg_s[STEPS][i]) begin
                prod_next[i] = IW'(0) - IW'(k_s[STEPS][i]);
            end else begin
                prod_next[i] = IW'(k_s[STEPS][i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= st_valid[STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            prod_reg <= prod_next;
            zero_reg <= zero_s[STEPS];
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_prod_w    = prod_reg[0];
    assign m_prod_x    = prod_reg[1];
    assign m_prod_y    = prod_reg[2];
    assign m_prod_z    = prod_reg[3];
    assign m_norm_zero = zero_reg;

    localparam logic signed [IW-1:0] UNIT = IW'(1) << FRAC_BITS;

    // a zero-norm result carries no component
    a_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_norm_zero |-> m_prod_w == '0 && m_prod_x == '0
                                   && m_prod_y == '0 && m_prod_z == '0)
        else $error("zero norm result with nonzero component");

    // a normalized component never exceeds one in magnitude
    a_unit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_norm_zero |-> m_prod_w <= UNIT && m_prod_w >= -UNIT
                                    && m_prod_x <= UNIT && m_prod_x >= -UNIT
                                    && m_prod_y <= UNIT && m_prod_y >= -UNIT
                                    && m_prod_z <= UNIT && m_prod_z >= -UNIT)
        else $error("normalized component above unit magnitude");

    // with the output register empty no stage may hold back the input
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while output register empty");

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the normalized quaternion product: directed and random requests, exact predictor
module tb_top;
    import qmn_pkg::*;

    localparam int FB      = 30;          // fraction bits of every component
    localparam int LATENCY = FB + 9;      // pipeline depth: product, norm, recurrence and output stages
    localparam logic signed [IW-1:0] ONE  = 32'sd1 <<< FB;
    localparam logic signed [IW-1:0] MAXV = 32'sh7fffffff;
    localparam logic signed [IW-1:0] MINV = 32'sh80000000;

    // expected normalized product of one request
    typedef struct packed {
        logic signed [IW-1:0] w;
        logic signed [IW-1:0] x;
        logic signed [IW-1:0] y;
        logic signed [IW-1:0] z;
        logic                 zero;
    } unit_prod_t;

    logic aclk;
    logic aresetn;
    logic s_valid, s_ready;
    logic signed [IW-1:0] s_now_w, s_now_x, s_now_y, s_now_z;
    logic signed [IW-1:0] s_old_w, s_old_x, s_old_y, s_old_z;
    logic m_valid, m_ready;
    logic signed [IW-1:0] m_prod_w, m_prod_x, m_prod_y, m_prod_z;
    logic m_norm_zero;

    unit_prod_t pending_prods[$];
    int errors;

    quaternion_multiply_normalize #(.FRAC_BITS(FB)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_now_w(s_now_w), .s_now_x(s_now_x), .s_now_y(s_now_y), .s_now_z(s_now_z),
        .s_old_w(s_old_w), .s_old_x(s_old_x), .s_old_y(s_old_y), .s_old_z(s_old_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_prod_w(m_prod_w), .m_prod_x(m_prod_x), .m_prod_y(m_prod_y),
        .m_prod_z(m_prod_z), .m_norm_zero(m_norm_zero)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #400000;
        $display("[quaternion_multiply_normalize] ERROR");
        $finish;
    end

    // one exact partial product, sign-extended to the product component width
    function automatic logic signed [CW-1:0] term(input logic signed [IW-1:0] a,
                                                   input logic signed [IW-1:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return {{(CW-PW){p[63]}}, p};
    endfunction

    // hamilton product now * old, then scale to unit length by exact rsqrt, truncated
    function automatic unit_prod_t hamilton_unit(
            input logic signed [IW-1:0] aw, ax, ay, az,
            input logic signed [IW-1:0] bw, bx, by, bz);
        logic signed [CW-1:0] c[4];
        logic [255:0] mag[4];
        logic [255:0] norm, lhs, cand, k;
        logic [IW-1:0] res[4];
        unit_prod_t r;
        c[0] = term(aw, bw) - term(ax, bx) - term(ay, by) - term(az, bz);
        c[1] = term(aw, bx) + term(ax, bw) + term(ay, bz) - term(az, by);
        c[2] = term(aw, by) - term(ax, bz) + term(ay, bw) + term(az, bx);
        c[3] = term(aw, bz) + term(ax, by) - term(ay, bx) + term(az, bw);
        norm = '0;
        for (int i = 0; i < 4; i++) begin
            mag[i] = '0;
            mag[i][CW-1:0] = c[i][CW-1] ? -c[i] : c[i];
            norm += mag[i] * mag[i];
        end
        if (norm == 0) begin
            r = '0;
            r.zero = 1'b1;
            return r;
        end
        for (int i = 0; i < 4; i++) begin
            lhs = (mag[i] * mag[i]) << (2 * FB);
            k = '0;
            // largest k with k^2 * norm <= c^2 * 2^(2*FB)
            for (int b = FB; b >= 0; b--) begin
                cand = k | (256'd1 << b);
                if (cand * cand * norm <= lhs) k = cand;
            end
            res[i] = c[i][CW-1] ? -k[IW-1:0] : k[IW-1:0];
        end
        r.w = res[0];
        r.x = res[1];
        r.y = res[2];
        r.z = res[3];
        r.zero = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [IW-1:0] got,
                                   input logic [IW-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // watch both channels; predict on each accepted request, check each result
    always @(posedge aclk) begin
        unit_prod_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                pending_prods.push_back(hamilton_unit(s_now_w, s_now_x, s_now_y, s_now_z,
                                                      s_old_w, s_old_x, s_old_y, s_old_z));
            if (m_valid && m_ready) begin
                if (pending_prods.size() == 0) begin
                    report_mismatch("unexpected result", m_prod_w, '0);
                end else begin
                    want = pending_prods.pop_front();
                    if (m_prod_w !== want.w) report_mismatch("prod_w", m_prod_w, want.w);
                    if (m_prod_x !== want.x) report_mismatch("prod_x", m_prod_x, want.x);
                    if (m_prod_y !== want.y) report_mismatch("prod_y", m_prod_y, want.y);
                    if (m_prod_z !== want.z) report_mismatch("prod_z", m_prod_z, want.z);
                    if (m_norm_zero !== want.zero)
                        report_mismatch("norm_zero", IW'(m_norm_zero), IW'(want.zero));
                end
            end
        end
    end

    // result side back-pressure: m_ready held low at random before each result, then ready until taken
    initial begin
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = $urandom_range(3);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // one request, after a random gap with valid low unless the gap draws zero; valid stays up across back-to-back
    task automatic send_pair(input logic signed [IW-1:0] aw, ax, ay, az,
                             input logic signed [IW-1:0] bw, bx, by, bz);
        int gap;
        gap = $urandom_range(3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_now_w <= aw; s_now_x <= ax; s_now_y <= ay; s_now_z <= az;
        s_old_w <= bw; s_old_x <= bx; s_old_y <= by; s_old_z <= bz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // full-range extremes and axis-aligned unit quaternions
    task automatic test_extremes();
        send_pair(ONE, 0, 0, 0, ONE, 0, 0, 0);
        send_pair(0, ONE, 0, 0, 0, ONE, 0, 0);
        send_pair(0, 0, ONE, 0, 0, 0, -ONE, 0);
        send_pair(0, 0, 0, ONE, ONE, 0, 0, 0);
        send_pair(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
        send_pair(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV);
        send_pair(MINV, MAXV, MINV, MAXV, MAXV, MINV, MAXV, MINV);
        send_pair(MINV, 0, 0, 0, MINV, 0, 0, 0);
        send_pair(1, 0, 0, 0, 1, 0, 0, 0);
        send_pair(-1, -1, -1, -1, 1, 1, 1, 1);
        send_pair(ONE, ONE, ONE, ONE, ONE, -ONE, -ONE, -ONE);
        send_pair(1, 2, 3, 4, MAXV, MINV, 5, -7);
    endtask

    // at least one quaternion all zero: product is zero, flag set and outputs cleared
    task automatic test_zero_norm();
        send_pair(0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(0, 0, 0, 0, MAXV, MINV, ONE, -1);
        send_pair(MINV, MAXV, -ONE, 1, 0, 0, 0, 0);
        send_pair(0, 0, 0, 0, 1, 0, 0, 0);
    endtask

    // component mix: full random, within unit range, tiny, extremes, plus or minus one and zero
    function automatic logic signed [IW-1:0] rand_comp();
        case ($urandom_range(9))
            0, 1, 2: return $urandom;
            3, 4, 5: return $signed($urandom_range(2 * ONE)) - ONE;
            6:       return $signed($urandom_range(15)) - 8;
            7:       return $urandom_range(1) ? MAXV : MINV;
            8:       return $urandom_range(1) ? ONE : -ONE;
            default: return 0;
        endcase
    endfunction

    task automatic test_random(input int count);
        logic signed [IW-1:0] a[4], b[4];
        for (int n = 0; n < count; n++) begin
            foreach (a[i]) a[i] = rand_comp();
            foreach (b[i]) b[i] = rand_comp();
            // now and then a fully zero operand
            if ($urandom_range(63) == 0) a = '{default: 0};
            if ($urandom_range(63) == 0) b = '{default: 0};
            send_pair(a[0], a[1], a[2], a[3], b[0], b[1], b[2], b[3]);
        end
    endtask

    initial begin
        errors = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_now_w <= '0; s_now_x <= '0; s_now_y <= '0; s_now_z <= '0;
        s_old_w <= '0; s_old_x <= '0; s_old_y <= '0; s_old_z <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes();
        test_zero_norm();
        test_random(1534);
        s_valid <= 1'b0;

        // drain, then let the pipeline settle
        while (pending_prods.size() != 0) @(posedge aclk);
        repeat (2 * LATENCY) @(posedge aclk);
        if (errors == 0 && pending_prods.size() == 0) begin
            $display("[quaternion_multiply_normalize] OK");
        end else begin
            $display("[quaternion_multiply_normalize] ERROR");
        end
        $finish;
    end

endmodule

// ===== quaternion_multiply_normalize.f =====
sv/qmn_pkg.sv
sv/qmn_hamilton.sv
sv/qmn_norm.sv
sv/qmn_rsqrt_step.sv
sv/quaternion_multiply_normalize.sv
tb/sv/tb_top.sv
